>>> src/lmhc_pkg.sv
package lmhc_pkg;

   // geometry
   localparam int MAX_WIDTH = 1024;
   localparam int X_W       = $clog2(MAX_WIDTH);
   localparam int Y_W       = 12;
   localparam int PIX_W     = 8;
   localparam int SLOTS     = 8;                   // lines held in the line store
   localparam int SLOT_W    = $clog2(SLOTS);
   localparam int WORD_W    = SLOTS * PIX_W;       // one column of all slots
   localparam int COLS      = SLOTS + 1;           // window is COLS x COLS
   localparam int BORDER    = COLS / 2;
   localparam int CSUM_W    = 12;
   localparam int WSUM_W    = 16;
   localparam int VALUE_W   = 7;

   // mean = floor(wsum / 1150) as (wsum * MEAN_RECIP) >> MEAN_SHIFT
   localparam int MEAN_RECIP = 14589;
   localparam int RECIP_W    = 14;
   localparam int MEAN_SHIFT = 24;
   localparam int MP_W       = WSUM_W + RECIP_W;
   localparam int MEAN_W     = MP_W - MEAN_SHIFT;

   // value = floor(d * 123 / 100), /100 as (n * PCT_RECIP) >> PCT_SHIFT
   localparam int GAIN       = 123;
   localparam int G_W        = 15;
   localparam int PCT_RECIP  = 5243;
   localparam int PCT_SHIFT  = 19;
   localparam int P_W        = 28;
   localparam int Q_W        = P_W - PCT_SHIFT;
   localparam int VALUE_MAX  = 125;

   typedef struct packed {
      logic [X_W-1:0] cx;
      logic [Y_W-1:0] cy;
      logic           last;
   } lmhc_tag_type;

   // one pixel beat at the line store
   typedef struct packed {
      logic [PIX_W-1:0]  pix;
      logic [X_W-1:0]    x;
      logic [SLOT_W-1:0] slot;
      logic              res;
      lmhc_tag_type      tag;
   } lmhc_pos_type;

   // one window result headed for the arithmetic
   typedef struct packed {
      logic [PIX_W-1:0]  centre;
      logic [WSUM_W-1:0] wsum;
      lmhc_tag_type      tag;
   } lmhc_win_type;

endpackage

>>> src/lmhc_ram.sv
module lmhc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024,
   localparam int AW = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr_a,
   input  logic [AW-1:0]    rd_addr_b,
   output logic [WIDTH-1:0] rd_data_a,
   output logic [WIDTH-1:0] rd_data_b
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // read returns the old word on a same-address write
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_a <= mem_ff[rd_addr_a];
         rd_data_b <= mem_ff[rd_addr_b];
      end
   end

endmodule

>>> src/lmhc_window.sv
module lmhc_window import lmhc_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         in_valid,
   output logic         in_ready,
   input  lmhc_pos_type in_pos,
   output logic         out_valid,
   input  logic         out_ready,
   output lmhc_win_type out_win
);

   logic              v1_ff;
   lmhc_pos_type      p1_ff;
   logic              v2_ff;
   lmhc_win_type      w2_ff;
   logic              rdy1, rdy2, acc, adv1;
   logic [WORD_W-1:0] rd_a, rd_b, word, cword, wr_word;
   logic              lw_v_ff;
   logic [X_W-1:0]    lw_addr_ff;
   logic [WORD_W-1:0] lw_data_ff;
   logic [CSUM_W-1:0] cs_ff [COLS-1];
   logic [WSUM_W-1:0] wsum_prev, wsum_in;
   logic [CSUM_W-1:0] csum;
   logic [PIX_W-1:0]  centre;
   logic [SLOT_W-1:0] cslot;

   assign rdy2     = !v2_ff || out_ready;
   assign rdy1     = !v1_ff || rdy2;
   assign in_ready = rdy1;
   assign acc      = in_valid && rdy1;
   assign adv1     = v1_ff && rdy2;

   lmhc_ram #(.WIDTH(WORD_W), .DEPTH(MAX_WIDTH)) u_ram (
      .clock     (clock),
      .wr_en     (adv1),
      .wr_addr   (p1_ff.x),
      .wr_data   (wr_word),
      .rd_en     (acc),
      .rd_addr_a (in_pos.x),
      .rd_addr_b (in_pos.tag.cx),
      .rd_data_a (rd_a),
      .rd_data_b (rd_b)
   );

   // last write-back may not be in the read data yet
   always_comb begin
      word    = (lw_v_ff && lw_addr_ff == p1_ff.x) ? lw_data_ff : rd_a;
      cword   = (lw_v_ff && lw_addr_ff == p1_ff.tag.cx) ? lw_data_ff : rd_b;
      cslot   = p1_ff.slot - SLOT_W'(BORDER);
      csum    = CSUM_W'(p1_ff.pix);
      wr_word = word;
      centre  = '0;
      for (int s = 0; s < SLOTS; s++) begin
         csum = csum + CSUM_W'(word[s*PIX_W +: PIX_W]);
         if (SLOT_W'(s) == p1_ff.slot) begin
            wr_word[s*PIX_W +: PIX_W] = p1_ff.pix;
         end
         if (SLOT_W'(s) == cslot) begin
            centre = cword[s*PIX_W +: PIX_W];
         end
      end
      // window sum: the eight previous column sums plus this one
      wsum_prev = '0;
      for (int k = 0; k < COLS - 1; k++) begin
         wsum_prev = wsum_prev + WSUM_W'(cs_ff[k]);
      end
      wsum_in = wsum_prev + WSUM_W'(csum);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff   <= 1'b0;
         v2_ff   <= 1'b0;
         lw_v_ff <= 1'b0;
         for (int k = 0; k < COLS - 1; k++) begin
            cs_ff[k] <= '0;
         end
      end else begin
         if (rdy1) begin
            v1_ff <= in_valid;
         end
         if (rdy2) begin
            v2_ff <= v1_ff && p1_ff.res;
         end
         if (adv1) begin
            lw_v_ff <= 1'b1;
            for (int k = 0; k < COLS - 2; k++) begin
               cs_ff[k] <= cs_ff[k+1];
            end
            cs_ff[COLS-2] <= csum;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (acc) begin
         p1_ff <= in_pos;
      end
      if (adv1) begin
         lw_addr_ff <= p1_ff.x;
         lw_data_ff <= wr_word;
      end
      if (rdy2) begin
         w2_ff.centre <= centre;
         w2_ff.wsum   <= wsum_in;
         w2_ff.tag    <= p1_ff.tag;
      end
   end

   assign out_valid = v2_ff;
   assign out_win   = w2_ff;

endmodule

>>> src/lmhc_scale.sv
module lmhc_scale import lmhc_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   output logic               in_ready,
   input  lmhc_win_type       in_win,
   output logic               out_valid,
   input  logic               out_ready,
   output lmhc_tag_type       out_tag,
   output logic [VALUE_W-1:0] out_value
);

   logic               v3_ff, v4_ff, v5_ff, vo_ff;
   logic               rdy3, rdy4, rdy5, rdyo;
   logic [MP_W-1:0]    mprod_ff;
   logic [PIX_W-1:0]   centre3_ff;
   logic [G_W-1:0]     gprod_ff, gprod_in;
   logic [P_W-1:0]     pprod_ff;
   lmhc_tag_type       tag3_ff, tag4_ff, tag5_ff, tago_ff;
   logic [VALUE_W-1:0] value_ff, value_in;
   logic [MEAN_W-1:0]  mean;
   logic [Q_W-1:0]     quot;

   assign rdyo     = !vo_ff || out_ready;
   assign rdy5     = !v5_ff || rdyo;
   assign rdy4     = !v4_ff || rdy5;
   assign rdy3     = !v3_ff || rdy4;
   assign in_ready = rdy3;

   // centre minus mean, times the gain
   always_comb begin
      mean = mprod_ff[MEAN_SHIFT +: MEAN_W];
      if (PIX_W'(mean) < centre3_ff) begin
         gprod_in = G_W'(centre3_ff - PIX_W'(mean)) * G_W'(GAIN);
      end else begin
         gprod_in = '0;
      end
   end

   // divide by 100 and clip
   always_comb begin
      quot = pprod_ff[PCT_SHIFT +: Q_W];
      if (quot > Q_W'(VALUE_MAX)) begin
         value_in = VALUE_W'(VALUE_MAX);
      end else begin
         value_in = quot[VALUE_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
         vo_ff <= 1'b0;
      end else begin
         if (rdy3) v3_ff <= in_valid;
         if (rdy4) v4_ff <= v3_ff;
         if (rdy5) v5_ff <= v4_ff;
         if (rdyo) vo_ff <= v5_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (rdy3) begin
         mprod_ff   <= MP_W'(in_win.wsum) * MP_W'(MEAN_RECIP);
         centre3_ff <= in_win.centre;
         tag3_ff    <= in_win.tag;
      end
      if (rdy4) begin
         gprod_ff <= gprod_in;
         tag4_ff  <= tag3_ff;
      end
      if (rdy5) begin
         pprod_ff <= P_W'(gprod_ff) * P_W'(PCT_RECIP);
         tag5_ff  <= tag4_ff;
      end
      if (rdyo) begin
         value_ff <= value_in;
         tago_ff  <= tag5_ff;
      end
   end

   assign out_valid = vo_ff;
   assign out_tag   = tago_ff;
   assign out_value = value_ff;

endmodule

>>> src/local_mean_highpass_clip_core.sv
// A result beat leaves once the pixel beat that completes its window has passed the
// line store read, column sum, mean multiply, gain multiply, /100 multiply and clip.
// Throughput: one pixel per cycle while rsp_tready does not stall the pipeline; the
// line store takes one read-modify-write per pixel. Border pixels give no result beat.
// Reset: position counters and column sums go to zero, line_width to 640, frame_height
// to 480; the line store is not cleared and holds data only once lines are written.
module local_mean_highpass_clip_core import lmhc_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   // pixel stream
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,    // [7:0] pixel
   input  logic        req_tuser,    // frame_start
   // result stream
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,    // [9:0] out_x, [21:10] out_y, [28:22] value, rest 0
   output logic        rsp_tlast,    // last_of_frame
   // register port
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   localparam logic REG_LINE_WIDTH   = 1'b0;
   localparam logic REG_FRAME_HEIGHT = 1'b1;
   localparam int   LW_W             = 11;
   localparam int   FH_W             = 12;
   localparam int   H_W              = Y_W + 1;
   localparam logic [LW_W-1:0] LW_RESET = 11'd640;
   localparam logic [FH_W-1:0] FH_RESET = 12'd480;

   logic [LW_W-1:0]    lw_ff;
   logic [FH_W-1:0]    fh_ff;
   logic [X_W-1:0]     col_ff, col_in;
   logic [Y_W-1:0]     row_ff, row_in;
   logic               csr_wr, acc;
   logic [LW_W-1:0]    w;
   logic [H_W-1:0]     h;
   logic [X_W-1:0]     c0, x;
   logic [Y_W-1:0]     r0, r1, y;
   lmhc_pos_type       pos;
   logic               win_valid, win_ready;
   lmhc_win_type       win;
   lmhc_tag_type       otag;
   logic [VALUE_W-1:0] ovalue;

   // next line number, wrapping at the frame height
   function automatic logic [Y_W-1:0] next_row(input logic [Y_W-1:0] r,
                                               input logic [H_W-1:0] hh);
      logic [H_W-1:0] r_p1;
      r_p1 = H_W'(r) + H_W'(1);
      return (r_p1 >= hh) ? '0 : r_p1[Y_W-1:0];
   endfunction

   // registers: word index taken from paddr[2]; pready tied high
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_prdata = (csr_paddr[2] == REG_FRAME_HEIGHT) ? 32'(fh_ff) : 32'(lw_ff);

   // effective sizes; a 12-bit height never exceeds the line count limit
   assign w = (lw_ff > LW_W'(MAX_WIDTH)) ? LW_W'(MAX_WIDTH) : lw_ff;
   assign h = H_W'(fh_ff);

   assign acc = req_tvalid && req_tready;

   // place the incoming pixel: frame_start restarts at (0,0), then any counter
   // that sits at or past its size wraps (column wrap also steps the row)
   always_comb begin
      c0 = req_tuser ? '0 : col_ff;
      r0 = req_tuser ? '0 : row_ff;
      if (LW_W'(c0) >= w) begin
         x  = '0;
         r1 = next_row(r0, h);
      end else begin
         x  = c0;
         r1 = r0;
      end
      y = (H_W'(r1) >= h) ? '0 : r1;

      if (LW_W'(x) + LW_W'(1) >= w) begin
         col_in = '0;
         row_in = next_row(y, h);
      end else begin
         col_in = x + X_W'(1);
         row_in = y;
      end

      pos.pix      = req_tdata;
      pos.x        = x;
      pos.slot     = y[SLOT_W-1:0];
      pos.res      = (x >= X_W'(COLS - 1)) && (y >= Y_W'(COLS - 1));
      pos.tag.cx   = x - X_W'(BORDER);
      pos.tag.cy   = y - Y_W'(BORDER);
      pos.tag.last = (LW_W'(x) + LW_W'(1) == w) && (H_W'(y) + H_W'(1) == h);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lw_ff  <= LW_RESET;
         fh_ff  <= FH_RESET;
         col_ff <= '0;
         row_ff <= '0;
      end else begin
         if (csr_wr) begin
            if (csr_paddr[2] == REG_LINE_WIDTH) begin
               lw_ff <= csr_pwdata[LW_W-1:0];
            end else begin
               fh_ff <= csr_pwdata[FH_W-1:0];
            end
         end
         if (acc) begin
            col_ff <= col_in;
            row_ff <= row_in;
         end
      end
   end

   // line store read-modify-write, column sums, running window sum
   lmhc_window u_window (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_pos    (pos),
      .out_valid (win_valid),
      .out_ready (win_ready),
      .out_win   (win)
   );

   // mean, gain and clip pipeline with the output register
   lmhc_scale u_scale (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (win_valid),
      .in_ready  (win_ready),
      .in_win    (win),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_tag   (otag),
      .out_value (ovalue)
   );

   assign rsp_tdata = {3'b000, ovalue, otag.cy, otag.cx};
   assign rsp_tlast = otag.last;

endmodule
